>>> rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and constants for the bounded shift array
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OP_W      = 4;
  localparam int IDX_W     = 7;
  localparam int VAL_W     = 64;
  localparam int CNT_OUT_W = 7;
  localparam int ERR_W     = 3;

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 4'd0,
    OP_POP       = 4'd1,
    OP_INSERT    = 4'd2,
    OP_ERASE     = 4'd3,
    OP_CLEAR     = 4'd4,
    OP_RESIZE    = 4'd5,
    OP_READ_CHK  = 4'd6,
    OP_READ_RAW  = 4'd7,
    OP_WRITE_RAW = 4'd8
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_INDEX = 3'd1,
    ERR_FULL  = 3'd2,
    ERR_EMPTY = 3'd3,
    ERR_SIZE  = 3'd4
  } err_t;

  // command broadcast from the control unit to every cell
  typedef struct packed {
    logic             en;   // update enable: accepted item with no error
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

>>> rtl/bsa_cell.sv
// ----------------------------------------------------------------------------
// bsa_cell
// one storage slot of the array, shifts with its neighbors on insert/erase
// ----------------------------------------------------------------------------
module bsa_cell #(
  parameter int DEPTH = bsa_pkg::DEPTH_DEFAULT,
  parameter int POS   = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bsa_pkg::cmd_t                     cmd,
  input  logic [$clog2(DEPTH+1)-1:0]        cnt,
  input  logic [bsa_pkg::VAL_W-1:0]         value,
  input  logic [bsa_pkg::VAL_W-1:0]         prev,
  input  logic [bsa_pkg::VAL_W-1:0]         next,
  output logic [bsa_pkg::VAL_W-1:0]         word
);
  import bsa_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CMPW-1:0] POS_E  = CMPW'(POS);
  localparam logic [CMPW-1:0] POS_P1 = CMPW'(POS + 1);

  logic [CMPW-1:0]  idx_e;
  logic [CMPW-1:0]  cnt_e;
  logic [VAL_W-1:0] word_next;

  assign idx_e = CMPW'(cmd.idx);
  assign cnt_e = CMPW'(cnt);

  always_comb begin
    word_next = word;
    if (cmd.en) begin
      case (cmd.op)
        OP_PUSH: begin
          if (POS_E == cnt_e) word_next = value;
        end
        OP_POP: begin
          if (POS_P1 == cnt_e) word_next = '0;
        end
        OP_INSERT: begin
          if (POS_E == idx_e) begin
            word_next = value;
          end else if (POS_E > idx_e && POS_E <= cnt_e) begin
            word_next = prev;
          end
        end
        OP_ERASE: begin
          // old last word stays put beyond the new count
          if (POS_E >= idx_e && POS_P1 < cnt_e) begin
            word_next = next;
          end else if (POS_E == idx_e) begin
            word_next = '0;
          end
        end
        OP_CLEAR: begin
          if (POS_E < cnt_e) word_next = '0;
        end
        OP_WRITE_RAW: begin
          if (POS_E == idx_e) word_next = value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else begin
      word <= word_next;
    end
  end

endmodule

>>> rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// op decode, bounds checks and the live count register
// ----------------------------------------------------------------------------
module bsa_ctrl #(
  parameter int DEPTH = bsa_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [bsa_pkg::OP_W-1:0]          op,
  input  logic [bsa_pkg::IDX_W-1:0]         idx,
  output bsa_pkg::cmd_t                     cmd,
  output bsa_pkg::err_t                     err,
  output logic                              rd_ok,
  output logic [$clog2(DEPTH+1)-1:0]        cnt,
  output logic [$clog2(DEPTH+1)-1:0]        cnt_next
);
  import bsa_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CMPW-1:0] DEPTH_E = CMPW'(DEPTH);

  op_t             op_dec;
  logic [CMPW-1:0] idx_e;
  logic [CMPW-1:0] cnt_e;

  assign op_dec = op_t'(op);
  assign idx_e  = CMPW'(idx);
  assign cnt_e  = CMPW'(cnt);

  always_comb begin
    err      = ERR_OK;
    rd_ok    = 1'b0;
    cnt_next = cnt;
    case (op_dec)
      OP_PUSH: begin
        if (cnt_e >= DEPTH_E) err = ERR_FULL;
        else                  cnt_next = cnt + CW'(1);
      end
      OP_POP: begin
        if (cnt == '0) err = ERR_EMPTY;
        else           cnt_next = cnt - CW'(1);
      end
      OP_INSERT: begin
        // index check wins over fullness
        if (idx_e >= cnt_e)        err = ERR_INDEX;
        else if (cnt_e >= DEPTH_E) err = ERR_FULL;
        else                       cnt_next = cnt + CW'(1);
      end
      OP_ERASE: begin
        if (idx_e >= cnt_e) err = ERR_INDEX;
        else                cnt_next = cnt - CW'(1);
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      OP_RESIZE: begin
        if (idx_e > DEPTH_E) err = ERR_SIZE;
        else                 cnt_next = CW'(idx_e);
      end
      OP_READ_CHK: begin
        if (idx_e >= cnt_e || idx_e >= DEPTH_E) err = ERR_INDEX;
        else                                    rd_ok = 1'b1;
      end
      OP_READ_RAW: begin
        if (idx_e >= DEPTH_E) err = ERR_INDEX;
        else                  rd_ok = 1'b1;
      end
      OP_WRITE_RAW: begin
        if (idx_e >= DEPTH_E) err = ERR_INDEX;
      end
      default: begin
      end
    endcase
  end

  assign cmd.en  = accept && (err == ERR_OK);
  assign cmd.op  = op_dec;
  assign cmd.idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(cnt) <= DEPTH_E)
    else $error("live count above capacity");

  a_err_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    accept && err != ERR_OK |=> cnt == $past(cnt))
    else $error("failed item changed the count");

  a_rd_no_err: assert property (@(posedge clk) disable iff (rst)
    rd_ok |-> err == ERR_OK && (op_dec == OP_READ_CHK || op_dec == OP_READ_RAW))
    else $error("read enable on a failing or non-read item");

endmodule

>>> rtl/bounded_shift_array.sv
// ----------------------------------------------------------------------------
// bounded_shift_array
// fixed-capacity list of 64-bit words with push/pop/insert/erase and reads
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lowest bit up)                | width
//  s_axis   | in  | op[3:0] index[10:4] value[74:11]            | 80
//  m_axis   | out | read_value[63:0] count[70:64] error[73:71]  | 80
//
//  one item per cycle while s_tready is high: every op, insert and erase included,
//  updates all cells in the cycle it is accepted, each cell taking its own word,
//  its left or right neighbor's word, the new value or zero; the read path is an
//  and-or select across the row into the output register, which sets the cycle time at large depths
//  a result is registered and appears in the cycle after its item is accepted
//  rst clears every cell and the count together, no clearing pass
//  s_tready drops only while a result sits unclaimed in the output register
// ----------------------------------------------------------------------------
module bounded_shift_array #(
  parameter int DEPTH = bsa_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,   // op, index, value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata    // read_value, count, error
);
  import bsa_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // input unpack
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] value;

  assign op    = s_tdata[OP_W-1:0];
  assign idx   = s_tdata[OP_W +: IDX_W];
  assign value = s_tdata[OP_W+IDX_W +: VAL_W];

  // a new item goes in whenever the output register is free or draining
  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // control
  cmd_t          cmd;
  err_t          err;
  logic          rd_ok;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  bsa_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .idx      (idx),
    .cmd      (cmd),
    .err      (err),
    .rd_ok    (rd_ok),
    .cnt      (cnt),
    .cnt_next (cnt_next)
  );

  // row of cells, each wired to its left and right neighbor
  logic [VAL_W-1:0] word [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] prev_w;
    logic [VAL_W-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_l
      assign prev_w = word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_r
      assign next_w = word[i+1];
    end

    bsa_cell #(
      .DEPTH (DEPTH),
      .POS   (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .cnt   (cnt),
      .value (value),
      .prev  (prev_w),
      .next  (next_w),
      .word  (word[i])
    );
  end

  // read select: and-or across the row, zero unless a good read
  logic [VAL_W-1:0] rd_word;
  logic [CMPW-1:0]  idx_e;
  assign idx_e = CMPW'(idx);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | (word[i] & {VAL_W{rd_ok && (CMPW'(i) == idx_e)}});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= M_TDATA_W'({err, CNT_OUT_W'(cnt_next), rd_word});
    end
  end

  a_cnt_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid && m_tdata[VAL_W +: CNT_OUT_W] == CNT_OUT_W'(cnt))
    else $error("count field does not match the live count");

  a_err_zero_rd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VAL_W+CNT_OUT_W +: ERR_W] != ERR_OK |->
      m_tdata[VAL_W-1:0] == '0)
    else $error("read value nonzero on a failed item");

  a_fail_keeps_cells: assert property (@(posedge clk) disable iff (rst)
    accept && err != ERR_OK |=> word[0] == $past(word[0]) &&
      word[DEPTH-1] == $past(word[DEPTH-1]))
    else $error("failed item changed the store");

endmodule

>>> test/bounded_shift_array_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_shift_array_tb
// drives list operations into the stream input and checks each result
// against a shadow copy of the list kept inside the bench
// ----------------------------------------------------------------------------
module bounded_shift_array_tb;
  import bsa_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int MAX_WAIT     = 12;
  localparam int RANDOM_ITEMS = 1400;
  // run limit, with room for both sides stalling on every item
  localparam int CYCLE_LIMIT  = 200000;
  // longer than the longest result stall, so a stray result still gets taken
  localparam int DRAIN_CYCLES = 2 * MAX_WAIT + 4;
  localparam int SEND_SIDE    = 0;
  localparam int RECV_SIDE    = 1;

  // op codes the block does not define; they must act as a no-op
  localparam logic [OP_W-1:0]  OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0]  OP_SPARE_HI = 4'd15;
  localparam logic [VAL_W-1:0] ALL_ONES    = '1;

  // bias of the random op mix over a stretch of items
  typedef enum int {GROW, SHRINK, MIXED} drift_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               hold;   // wait for every outstanding result first
  } list_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]     rdata;
    logic [CNT_OUT_W-1:0] cnt;
    err_t                 err;
  } list_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // op, index, value
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // read_value, count, error

  bounded_shift_array #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow list: the words and the live count as the block should hold them
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0] shadow_cells [DEPTH] = '{default: '0};
  int               shadow_count = 0;
  int               peak_count   = 0;

  function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [VAL_W-1:0] val);
    list_result_t r;
    int           ix;
    int           i;
    ix      = int'(idx);
    r.rdata = '0;
    r.err   = ERR_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.err = ERR_FULL;
        end else begin
          shadow_cells[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.err = ERR_EMPTY;
        end else begin
          shadow_count--;
          shadow_cells[shadow_count] = '0;
        end
      end
      OP_INSERT: begin
        // the index check wins over the full check
        if (ix >= shadow_count) begin
          r.err = ERR_INDEX;
        end else if (shadow_count >= DEPTH) begin
          r.err = ERR_FULL;
        end else begin
          for (i = shadow_count; i > ix; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[ix] = val;
          shadow_count++;
        end
      end
      OP_ERASE: begin
        // the old last word is left in place past the new count
        if (ix >= shadow_count) begin
          r.err = ERR_INDEX;
        end else begin
          shadow_cells[ix] = '0;
          for (i = ix; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < shadow_count; i++) shadow_cells[i] = '0;
        shadow_count = 0;
      end
      OP_RESIZE: begin
        if (ix > DEPTH) begin
          r.err = ERR_SIZE;
        end else begin
          shadow_count = ix;
        end
      end
      OP_READ_CHK: begin
        if (ix >= shadow_count || ix >= DEPTH) begin
          r.err = ERR_INDEX;
        end else begin
          r.rdata = shadow_cells[ix];
        end
      end
      OP_READ_RAW: begin
        if (ix >= DEPTH) begin
          r.err = ERR_INDEX;
        end else begin
          r.rdata = shadow_cells[ix];
        end
      end
      OP_WRITE_RAW: begin
        if (ix >= DEPTH) begin
          r.err = ERR_INDEX;
        end else begin
          shadow_cells[ix] = val;
        end
      end
      default: begin
      end
    endcase
    r.cnt = CNT_OUT_W'(shadow_count);
    if (shadow_count > peak_count) peak_count = shadow_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus planning
  // --------------------------------------------------------------------------
  list_cmd_t    pending_cmds [$];
  list_result_t want_results [$];

  // live count as the queued items will leave it; only the count is tracked
  // so that indexes can be aimed at live words
  int plan_count = 0;

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                    logic [VAL_W-1:0] val, bit hold);
    list_cmd_t c;
    int        ix;
    ix     = int'(idx);
    c.op   = op;
    c.idx  = idx;
    c.val  = val;
    c.hold = hold;
    pending_cmds = {pending_cmds, c};
    case (op)
      OP_PUSH:   if (plan_count < DEPTH) plan_count++;
      OP_POP:    if (plan_count > 0) plan_count--;
      OP_INSERT: if (ix < plan_count && plan_count < DEPTH) plan_count++;
      OP_ERASE:  if (ix < plan_count) plan_count--;
      OP_CLEAR:  plan_count = 0;
      OP_RESIZE: if (ix <= DEPTH) plan_count = ix;
      default: begin
      end
    endcase
  endfunction

  function automatic list_cmd_t plan_cmd(drift_t drift);
    list_cmd_t c;
    int        grow_w;
    int        shrink_w;
    int        pick;
    grow_w   = (drift == GROW) ? 60 : (drift == SHRINK) ? 15 : 35;
    shrink_w = (drift == SHRINK) ? 60 : (drift == GROW) ? 15 : 35;
    pick     = $urandom_range(0, 99);
    if (pick < grow_w) begin
      c.op = $urandom_range(0, 1) ? OP_INSERT : OP_PUSH;
    end else if (pick < grow_w + shrink_w) begin
      c.op = $urandom_range(0, 1) ? OP_ERASE : OP_POP;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 18, 19: c.op = OP_READ_CHK;
        8, 9, 10:                       c.op = OP_READ_RAW;
        11, 12, 13:                     c.op = OP_WRITE_RAW;
        14, 15:                         c.op = OP_RESIZE;
        16:                             c.op = OP_CLEAR;
        default:                        c.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      endcase
    end

    // mostly aim at live words or valid slots, sometimes anywhere at all
    if (c.op == OP_RESIZE) begin
      c.idx = ($urandom_range(0, 5) == 0) ? IDX_W'($urandom_range(DEPTH + 1, IDX_MAX))
                                          : IDX_W'($urandom_range(0, DEPTH));
    end else if ($urandom_range(0, 9) < 8) begin
      if (c.op == OP_READ_RAW || c.op == OP_WRITE_RAW) begin
        c.idx = IDX_W'($urandom_range(0, DEPTH - 1));
      end else if (plan_count > 0) begin
        c.idx = IDX_W'($urandom_range(0, plan_count - 1));
      end else begin
        c.idx = IDX_W'($urandom_range(0, IDX_MAX));
      end
    end else begin
      c.idx = IDX_W'($urandom_range(0, IDX_MAX));
    end

    case ($urandom_range(0, 9))
      0:       c.val = '0;
      1:       c.val = ALL_ONES;
      default: c.val = {$urandom, $urandom};
    endcase
    c.hold = ($urandom_range(0, 199) == 0);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // idle gaps: each side runs stretches of random waits and stretches of none
  // --------------------------------------------------------------------------
  int idle_stretch [2] = '{0, 0};
  bit idle_quiet   [2] = '{0, 0};

  function automatic int draw_wait(int side);
    if (idle_stretch[side] == 0) begin
      idle_quiet[side]   = ($urandom_range(0, 3) == 0);
      idle_stretch[side] = $urandom_range(10, 60);
    end
    idle_stretch[side]--;
    return idle_quiet[side] ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // driver: presents queued items on the input stream at the falling edge
  // --------------------------------------------------------------------------
  bit in_taken  = 1'b0;   // an input item was accepted at the last rising edge
  bit out_taken = 1'b0;   // a result was accepted at the last rising edge
  int send_wait = 0;
  int recv_wait = 0;
  int holds_done = 0;

  always @(negedge clk) begin : driver_blk
    list_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      // the input slot is free: idle, wait for the block to drain, or send
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].hold && want_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        if (c.hold) holds_done++;
        s_tdata   <= S_TDATA_W'({c.val, c.idx, c.op});
        s_tvalid  <= 1'b1;
        send_wait = draw_wait(SEND_SIDE);
      end
    end
  end

  // result side: a drawn stall per result, counted only while one is waiting
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) recv_wait = draw_wait(RECV_SIDE);
      if (recv_wait > 0) begin
        if (m_tvalid) recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks results and predicts accepted items at the rising edge
  // --------------------------------------------------------------------------
  int fails     = 0;
  int cycle_no  = 0;
  int items_in  = 0;
  int checked   = 0;
  int op_seen  [16] = '{default: 0};
  int err_seen [8]  = '{default: 0};

  function automatic void note_mismatch(string what, logic [VAL_W-1:0] want_v,
                                        logic [VAL_W-1:0] got_v);
    fails++;
    $display("%0t %s: expected %h, got %h", $time, what, want_v, got_v);
  endfunction

  always @(posedge clk) begin : monitor_blk
    list_result_t want;
    list_result_t got;
    cycle_no++;
    in_taken  <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;

    // result first: it belongs to an item accepted at an earlier edge
    if (!rst && m_tvalid && m_tready) begin
      got.rdata = m_tdata[VAL_W-1:0];
      got.cnt   = m_tdata[VAL_W +: CNT_OUT_W];
      got.err   = err_t'(m_tdata[VAL_W+CNT_OUT_W +: ERR_W]);
      if (want_results.size() == 0) begin
        note_mismatch("result with none pending", '0, got.rdata);
      end else begin
        want = want_results.pop_front();
        checked++;
        if (got.rdata !== want.rdata) note_mismatch("read_value", want.rdata, got.rdata);
        if (got.cnt !== want.cnt) note_mismatch("count", VAL_W'(want.cnt), VAL_W'(got.cnt));
        if (got.err !== want.err) note_mismatch("error", VAL_W'(want.err), VAL_W'(got.err));
      end
    end

    if (!rst && s_tvalid && s_tready) begin
      want = predict_list_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: IDX_W],
                             s_tdata[OP_W+IDX_W +: VAL_W]);
      want_results = {want_results, want};
      items_in++;
      op_seen[s_tdata[OP_W-1:0]]++;
      err_seen[want.err]++;
    end

    if (cycle_no >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_no, want_results.size());
      $display("bounded_shift_array_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: directed corner cases, then biased random stretches
  // --------------------------------------------------------------------------
  initial begin
    list_cmd_t c;
    drift_t    drift;
    int        left;
    int        spares;
    drift = MIXED;
    left  = 0;

    // empty list: every way of touching it must fail or do nothing
    queue_cmd(OP_POP, 0, '0, 1'b0);
    queue_cmd(OP_ERASE, 0, '0, 1'b0);
    queue_cmd(OP_READ_CHK, 0, '0, 1'b0);
    queue_cmd(OP_CLEAR, 0, '0, 1'b0);
    // a few words with extreme and mixed patterns
    queue_cmd(OP_PUSH, 0, ALL_ONES, 1'b0);
    queue_cmd(OP_PUSH, 0, '0, 1'b0);
    queue_cmd(OP_PUSH, 0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    queue_cmd(OP_INSERT, 0, 64'h0123_4567_89AB_CDEF, 1'b0);
    // insert at the end is refused as a bad index
    queue_cmd(OP_INSERT, 4, 64'h1111_2222_3333_4444, 1'b0);
    queue_cmd(OP_INSERT, 3, 64'hDEAD_BEEF_0000_0001, 1'b0);
    queue_cmd(OP_READ_CHK, 4, '0, 1'b0);
    queue_cmd(OP_READ_CHK, 5, '0, 1'b0);
    // erase in the middle leaves the old last word past the count
    queue_cmd(OP_ERASE, 1, '0, 1'b0);
    queue_cmd(OP_READ_RAW, 4, '0, 1'b0);
    // erase of the last live word leaves its slot zero
    queue_cmd(OP_ERASE, 3, '0, 1'b0);
    queue_cmd(OP_READ_RAW, 3, '0, 1'b0);
    // raw access at and past the top slot
    queue_cmd(OP_WRITE_RAW, IDX_W'(DEPTH - 1), ALL_ONES, 1'b0);
    queue_cmd(OP_WRITE_RAW, IDX_W'(IDX_MAX), 64'h5555_AAAA_5555_AAAA, 1'b0);
    queue_cmd(OP_READ_RAW, IDX_W'(DEPTH), '0, 1'b0);
    // grow to full by resize, keeping contents, then hit the full and index checks
    queue_cmd(OP_RESIZE, IDX_W'(DEPTH), '0, 1'b0);
    queue_cmd(OP_PUSH, 0, 64'h0000_0000_0000_0001, 1'b0);
    queue_cmd(OP_INSERT, IDX_W'(DEPTH), 64'h8000_0000_0000_0000, 1'b0);
    queue_cmd(OP_INSERT, 0, 64'h8000_0000_0000_0000, 1'b0);
    queue_cmd(OP_READ_CHK, IDX_W'(DEPTH - 1), '0, 1'b0);
    // pop from full zeroes the freed slot
    queue_cmd(OP_POP, 0, '0, 1'b0);
    queue_cmd(OP_READ_RAW, IDX_W'(DEPTH - 1), '0, 1'b0);
    // sizes past capacity
    queue_cmd(OP_RESIZE, IDX_W'(DEPTH + 1), '0, 1'b0);
    queue_cmd(OP_RESIZE, IDX_W'(IDX_MAX), '0, 1'b0);
    queue_cmd(OP_CLEAR, 0, '0, 1'b0);
    queue_cmd(OP_READ_RAW, 0, '0, 1'b0);
    // undefined codes with live-looking operands must change nothing
    queue_cmd(OP_SPARE_LO, 0, ALL_ONES, 1'b0);
    queue_cmd(OP_SPARE_HI, IDX_W'(IDX_MAX), ALL_ONES, 1'b0);
    queue_cmd(OP_RESIZE, 0, '0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (left == 0) begin
        drift = drift_t'($urandom_range(0, 2));
        left  = $urandom_range(30, 120);
      end
      left--;
      c = plan_cmd(drift);
      // the first random item waits until the directed part has fully drained
      if (n == 0) c.hold = 1'b1;
      queue_cmd(c.op, c.idx, c.val, c.hold);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid || want_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    spares = 0;
    for (int k = int'(OP_SPARE_LO); k <= int'(OP_SPARE_HI); k++) spares += op_seen[k];
    $display("items %0d (push %0d pop %0d ins %0d erase %0d clr %0d resize %0d rd %0d/%0d wr %0d undef %0d)",
             items_in, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_INSERT],
             op_seen[OP_ERASE], op_seen[OP_CLEAR], op_seen[OP_RESIZE],
             op_seen[OP_READ_CHK], op_seen[OP_READ_RAW], op_seen[OP_WRITE_RAW], spares);
    $display("  %0d checked; errors idx %0d full %0d empty %0d size %0d; peak %0d, %0d drains",
             checked, err_seen[ERR_INDEX], err_seen[ERR_FULL], err_seen[ERR_EMPTY],
             err_seen[ERR_SIZE], peak_count, holds_done);
    if (fails == 0) begin
      $display("bounded_shift_array_tb: PASS");
    end else begin
      $display("bounded_shift_array_tb: FAIL");
    end
    $finish;
  end

endmodule
